[rtl/core/fsmtc_pkg.sv]
// Package for the fan speed, mode and off-timer controller.
// Holds event codes, register indexes, reset values and level arithmetic.
// No dependencies.
`default_nettype none

package fsmtc_pkg;

  localparam int unsigned TimeW  = 9;
  localparam int unsigned LevelW = 3;
  localparam int unsigned TempW  = 8;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 9;

  localparam logic [TimeW-1:0]  InitialTimeRst = 9'd30;
  localparam logic [TimeW-1:0]  TimeStepRst    = 9'd30;
  localparam logic [TimeW-1:0]  TimeLimitRst   = 9'd300;
  localparam logic [LevelW-1:0] MaxLevelRst    = 3'd4;
  localparam logic [TimeW-1:0]  TimeLeftRst    = 9'd30;

  localparam int unsigned DutyPerLevel = 25;
  // temperature / 20 as (temperature * 205) >> 12, exact for 8-bit values
  localparam logic [7:0]  RecipTwenty  = 8'd205;
  localparam int unsigned RecipShift   = 12;

  typedef enum logic [OpW-1:0] {
    OP_SAMPLE  = 3'd0,
    OP_MODE    = 3'd1,
    OP_SPEED   = 3'd2,
    OP_TIMER   = 3'd3,
    OP_ADDTIME = 3'd4,
    OP_TICK    = 3'd5
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INITIAL_TIME = 2'd0,
    REG_TIME_STEP    = 2'd1,
    REG_TIME_LIMIT   = 2'd2,
    REG_MAX_LEVEL    = 2'd3
  } cfg_reg_e;

  function automatic logic [3:0] temp_to_level(input logic [TempW-1:0] temp);
    logic [15:0] prod;
    prod = temp * RecipTwenty;
    return prod[RecipShift +: 4];
  endfunction

  function automatic logic [DutyW-1:0] level_to_duty(input logic [LevelW-1:0] lvl);
    logic [DutyW-1:0] duty;
    duty = {{(DutyW-LevelW){1'b0}}, lvl} * DutyW'(DutyPerLevel);
    return duty;
  endfunction

endpackage

`default_nettype wire

[rtl/core/fan_speed_mode_timer_control_core.sv]
// Top level of the fan speed, mode and off-timer controller.
// Path: input register, then result register; a stalled result holds the item in the input register.
// Throughput: one item per cycle while the output is not stalled; the event decode and state update are combinational.
// An item is taken while a finished result still waits in the result register.
// Reset: mode automatic, level 0, timer off, 30 s left, lamp off, registers at defaults.
// Depends on fsmtc_pkg.
`default_nettype none

module fan_speed_mode_timer_control_core import fsmtc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [OpW-1:0]      opcode_i,
  input  wire logic [TempW-1:0]    temperature_i,
  input  wire logic                motion_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [DutyW-1:0]         fan_duty_o,
  output logic [LevelW-1:0]        level_now_o,
  output logic                     automatic_res_o,
  output logic                     timer_active_o,
  output logic [TimeW-1:0]         seconds_left_o,
  output logic                     lamp_o
);

  // configuration registers
  logic [TimeW-1:0]  initial_time_q, time_step_q, time_limit_q;
  logic [LevelW-1:0] max_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_time_q <= InitialTimeRst;
      time_step_q    <= TimeStepRst;
      time_limit_q   <= TimeLimitRst;
      max_level_q    <= MaxLevelRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_INITIAL_TIME: initial_time_q <= cfg_data_i[TimeW-1:0];
        REG_TIME_STEP:    time_step_q    <= cfg_data_i[TimeW-1:0];
        REG_TIME_LIMIT:   time_limit_q   <= cfg_data_i[TimeW-1:0];
        REG_MAX_LEVEL:    max_level_q    <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_vld_q;
  logic adv;
  logic take_in;

  assign adv        = in_vld_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign take_in    = in_valid_i && in_ready_o;

  // input register
  logic [OpW-1:0]   op_q;
  logic [TempW-1:0] temp_q;
  logic             motion_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      op_q     <= opcode_i;
      temp_q   <= temperature_i;
      motion_q <= motion_i;
    end
  end

  // controller state
  logic              auto_q, auto_d;
  logic [LevelW-1:0] level_q, level_d;
  logic              timer_q, timer_d;
  logic [TimeW-1:0]  left_q, left_d;
  logic              lamp_q, lamp_d;

  logic [3:0]        temp_lv;
  logic [TimeW:0]    add_sum;
  logic              left_nz;

  assign temp_lv = temp_to_level(temp_q);
  assign add_sum = {1'b0, left_q} + {1'b0, time_step_q};
  assign left_nz = (left_q != '0);

  always_comb begin
    auto_d  = auto_q;
    level_d = level_q;
    timer_d = timer_q;
    left_d  = left_q;
    lamp_d  = lamp_q;
    case (opcode_e'(op_q))
      OP_SAMPLE: begin
        lamp_d = motion_q;
        if (auto_q && left_nz) begin
          level_d = (temp_lv > {1'b0, max_level_q}) ? max_level_q : temp_lv[LevelW-1:0];
        end
      end
      OP_MODE: begin
        auto_d = !auto_q;
      end
      OP_SPEED: begin
        if (!auto_q) begin
          level_d = (level_q >= max_level_q) ? '0 : level_q + LevelW'(1);
        end
      end
      OP_TIMER: begin
        timer_d = !timer_q;
        left_d  = initial_time_q;
      end
      OP_ADDTIME: begin
        // wrap back to one step at or beyond the limit
        if (timer_q && left_nz) begin
          left_d = (add_sum >= {1'b0, time_limit_q}) ? time_step_q : add_sum[TimeW-1:0];
        end
      end
      OP_TICK: begin
        if (timer_q && left_nz) begin
          left_d = left_q - TimeW'(1);
        end
      end
      default: ;
    endcase
    // expired off-timer holds the fan stopped
    if (timer_d && (left_d == '0)) begin
      level_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q  <= 1'b1;
      level_q <= '0;
      timer_q <= 1'b0;
      left_q  <= TimeLeftRst;
      lamp_q  <= 1'b0;
    end else if (adv) begin
      auto_q  <= auto_d;
      level_q <= level_d;
      timer_q <= timer_d;
      left_q  <= left_d;
      lamp_q  <= lamp_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || out_ready_i) begin
      out_valid_o <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fan_duty_o      <= level_to_duty(level_d);
      level_now_o     <= level_d;
      automatic_res_o <= auto_d;
      timer_active_o  <= timer_d;
      seconds_left_o  <= left_d;
      lamp_o          <= lamp_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fsmtc_checker.sv]
// Port-level checks for the fan speed, mode and off-timer controller.
// Bound to fan_speed_mode_timer_control_core; depends on fsmtc_pkg.
`default_nettype none

module fsmtc_checker import fsmtc_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [DutyW-1:0]  fan_duty_o,
  input wire logic [LevelW-1:0] level_now_o,
  input wire logic              timer_active_o,
  input wire logic [TimeW-1:0]  seconds_left_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_now_o)
      && $stable(seconds_left_o))
    else $error("result changed while stalled");

  // input side only stalls behind a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fan_duty_o == level_to_duty(level_now_o))
    else $error("duty does not follow level");

  // expired off-timer keeps the fan stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timer_active_o && (seconds_left_o == '0) |-> level_now_o == '0)
    else $error("fan running after off-timer expired");

endmodule

bind fan_speed_mode_timer_control_core fsmtc_checker u_fsmtc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .fan_duty_o     (fan_duty_o),
  .level_now_o    (level_now_o),
  .timer_active_o (timer_active_o),
  .seconds_left_o (seconds_left_o)
);

`default_nettype wire
